[rtl/cfsl_pkg.sv]
// ----------------------------------------------------------------------------
// cfsl_pkg
// Shared types, codes and the frame CRC for the serial command link master.
// ----------------------------------------------------------------------------
package cfsl_pkg;

	localparam int FRAME_BITS = 64;
	localparam int RESP_BITS  = 32;
	localparam int COUNT_W    = 7;

	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Register indexes of the configuration port.
	localparam logic REG_HEADER_FIRST  = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	// Input word modes.
	localparam logic MODE_START  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TX_HI = 3'd1,
		PH_TX_LO = 3'd2,
		PH_RX_HI = 3'd3,
		PH_RX_LO = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
	} cfg_t;

	// One word as it enters the handshake engine, with its frame built.
	typedef struct packed {
		logic                  mode;
		logic                  ack_level;
		logic                  data_level;
		logic [FRAME_BITS-1:0] frame;
	} item_t;

	// CRC over the six leading frame bytes, taken as three little-endian
	// 16-bit words fed MSB first. The loop is a fixed XOR network.
	function automatic logic [15:0] crc_of_head(input logic [47:0] head);
		logic [47:0] stream;
		logic [15:0] crc;
		logic        top;
		stream = {head[39:32], head[47:40], head[23:16], head[31:24],
			head[7:0], head[15:8]};
		crc = CRC_INIT;
		for (int i = 47; i >= 0; i--) begin
			top = crc[15];
			crc = {crc[14:0], stream[i]};
			if (top) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

[rtl/cfsl_if.sv]
// ----------------------------------------------------------------------------
// cfsl_in_if / cfsl_out_if
// Valid/ready channels for command and sample words, and for result words.
// ----------------------------------------------------------------------------
interface cfsl_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] command_word;
	logic        ack_level;
	logic        data_level;

	modport source (output valid, mode, command_word, ack_level, data_level,
		input ready);
	modport sink (input valid, mode, command_word, ack_level, data_level,
		output ready);
endinterface

interface cfsl_out_if;
	logic        valid;
	logic        ready;
	logic        strobe_line;
	logic        send_line;
	logic [31:0] response_word;
	logic        response_valid;
	logic        busy_res;
	logic        start_rejected;

	modport source (output valid, strobe_line, send_line, response_word,
		response_valid, busy_res, start_rejected, input ready);
	modport sink (input valid, strobe_line, send_line, response_word,
		response_valid, busy_res, start_rejected, output ready);
endinterface

[rtl/cfsl_regs.sv]
// ----------------------------------------------------------------------------
// cfsl_regs
// APB-style register file holding the two frame header bytes.
// ----------------------------------------------------------------------------
module cfsl_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfsl_pkg::cfg_t     cfg
);
	import cfsl_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_HEADER_FIRST:  cfg_q.header_first  <= pwdata[7:0];
				REG_HEADER_SECOND: cfg_q.header_second <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HEADER_FIRST:  prdata = {24'd0, cfg_q.header_first};
			REG_HEADER_SECOND: prdata = {24'd0, cfg_q.header_second};
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/cfsl_frame.sv]
// ----------------------------------------------------------------------------
// cfsl_frame
// Input register and frame build stage: header, command and CRC.
// ----------------------------------------------------------------------------
module cfsl_frame (
	input  logic               clk,
	input  logic               arst_n,
	cfsl_in_if.sink            cmd_in,
	input  cfsl_pkg::cfg_t     cfg,
	input  logic               advance,
	output logic               item_valid,
	output cfsl_pkg::item_t    item
);
	import cfsl_pkg::*;

	logic        valid_s1;
	logic        mode_s1;
	logic [31:0] cmd_s1;
	logic        ack_s1;
	logic        dat_s1;

	logic        valid_s2;
	item_t       item_s2;

	logic [47:0] head;
	logic [15:0] crc;

	assign cmd_in.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s1 <= cmd_in.mode;
			cmd_s1  <= cmd_in.command_word;
			ack_s1  <= cmd_in.ack_level;
			dat_s1  <= cmd_in.data_level;
		end
	end

	// Headers read here; the user must keep them stable while words are in flight.
	assign head = {cfg.header_first, cfg.header_second, cmd_s1};
	assign crc  = crc_of_head(head);

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2.mode       <= mode_s1;
			item_s2.ack_level  <= ack_s1;
			item_s2.data_level <= dat_s1;
			item_s2.frame      <= {head, crc};
		end
	end

	assign item_valid = valid_s2;
	assign item       = item_s2;

endmodule

[rtl/cfsl_engine.sv]
// ----------------------------------------------------------------------------
// cfsl_engine
// Handshake sequencer for the serial link and the result register.
// ----------------------------------------------------------------------------
module cfsl_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  cfsl_pkg::item_t    item,
	output logic               advance,
	cfsl_out_if.source         res_out
);
	import cfsl_pkg::*;

	phase_t                phase_q, phase_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic [COUNT_W-1:0]    bits_q, bits_d;
	logic [RESP_BITS-1:0]  resp_q, resp_d;
	logic                  strobe_q, strobe_d;
	logic                  data_q, data_d;

	logic                  busy;
	logic                  step;
	logic [COUNT_W-1:0]    bits_dec;
	logic [RESP_BITS-1:0]  resp_shifted;
	logic [FRAME_BITS-1:0] frame_shifted;
	logic                  done_valid;
	logic                  rejected;
	logic [RESP_BITS-1:0]  done_word;

	logic                  out_valid_q;
	logic                  strobe_line_q;
	logic                  send_line_q;
	logic [RESP_BITS-1:0]  response_word_q;
	logic                  response_valid_q;
	logic                  busy_res_q;
	logic                  start_rejected_q;

	assign advance       = !out_valid_q || res_out.ready;
	assign step          = item_valid && advance;
	assign busy          = (phase_q != PH_IDLE);
	assign bits_dec      = bits_q - COUNT_W'(1);
	assign resp_shifted  = {resp_q[RESP_BITS-2:0], item.data_level};
	assign frame_shifted = {frame_q[FRAME_BITS-2:0], 1'b0};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (item.mode == MODE_START) begin
			if (!busy) begin
				phase_d = PH_TX_HI;
			end
		end else begin
			case (phase_q)
				PH_TX_HI: if (item.ack_level) phase_d = PH_TX_LO;
				PH_TX_LO: begin
					if (!item.ack_level) begin
						phase_d = (bits_dec != '0) ? PH_TX_HI : PH_RX_HI;
					end
				end
				PH_RX_HI: if (item.ack_level) phase_d = PH_RX_LO;
				PH_RX_LO: begin
					if (!item.ack_level) begin
						phase_d = (bits_dec != '0) ? PH_RX_HI : PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Datapath and result fields.
	always_comb begin
		frame_d    = frame_q;
		bits_d     = bits_q;
		resp_d     = resp_q;
		strobe_d   = strobe_q;
		data_d     = data_q;
		done_valid = 1'b0;
		done_word  = '0;
		rejected   = 1'b0;
		if (item.mode == MODE_START) begin
			if (busy) begin
				rejected = 1'b1;
			end else begin
				frame_d  = item.frame;
				bits_d   = COUNT_W'(FRAME_BITS);
				resp_d   = '0;
				strobe_d = 1'b1;
				data_d   = item.frame[FRAME_BITS-1];
			end
		end else begin
			case (phase_q)
				PH_TX_HI: if (item.ack_level) strobe_d = 1'b0;
				PH_TX_LO: begin
					if (!item.ack_level) begin
						frame_d = frame_shifted;
						if (bits_dec != '0) begin
							bits_d   = bits_dec;
							strobe_d = 1'b1;
							data_d   = frame_shifted[FRAME_BITS-1];
						end else begin
							bits_d = COUNT_W'(RESP_BITS);
						end
					end
				end
				PH_RX_HI: if (item.ack_level) strobe_d = 1'b1;
				PH_RX_LO: begin
					if (!item.ack_level) begin
						resp_d   = resp_shifted;
						strobe_d = 1'b0;
						bits_d   = bits_dec;
						if (bits_dec == '0) begin
							done_valid = 1'b1;
							done_word  = resp_shifted;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			frame_q  <= '0;
			bits_q   <= '0;
			resp_q   <= '0;
			strobe_q <= 1'b0;
			data_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			frame_q  <= frame_d;
			bits_q   <= bits_d;
			resp_q   <= resp_d;
			strobe_q <= strobe_d;
			data_q   <= data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			strobe_line_q    <= strobe_d;
			send_line_q      <= data_d;
			response_word_q  <= done_word;
			response_valid_q <= done_valid;
			busy_res_q       <= (phase_d != PH_IDLE);
			start_rejected_q <= rejected;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.strobe_line    = strobe_line_q;
	assign res_out.send_line      = send_line_q;
	assign res_out.response_word  = response_word_q;
	assign res_out.response_valid = response_valid_q;
	assign res_out.busy_res       = busy_res_q;
	assign res_out.start_rejected = start_rejected_q;

endmodule

[rtl/crc_framed_serial_command_link_core.sv]
// ----------------------------------------------------------------------------
// crc_framed_serial_command_link_core
// Master side of a two-wire strobe/ack command link with a CRC-framed command.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word, and one word is taken per
// clock unless the result stalls. Each word passes an input register, a
// frame stage that builds the 8-byte frame (two header bytes, the command
// big-endian and a CRC-16 with polynomial 0x8005, init 0xFFFF, over the six
// leading bytes as little-endian words) and the handshake sequencer that
// writes the result register. The three stages stall together when the
// result is not taken. A start word (mode 0) loads the frame and drives its
// first bit; sample words (mode 1) each carry one look at the partner's ack
// and data lines and advance the handshake by at most one phase: 64 frame
// bits out, then 32 response bits in, MSB first. The response shows on the
// word that samples its last bit, with response_valid set; a start while an
// exchange is still in progress is dropped and flagged in start_rejected.
// The header bytes sit at byte addresses 0 and 4 of the APB port; the user must
// write them only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module crc_framed_serial_command_link_core (
	input  logic        clk,
	input  logic        arst_n,
	cfsl_in_if.sink     cmd_in,
	cfsl_out_if.source  res_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cfsl_pkg::*;

	cfg_t  cfg;
	logic  advance;
	logic  item_valid;
	item_t item;

	// Header registers; they feed the frame stage directly.
	cfsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register and frame build with the CRC.
	cfsl_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_in     (cmd_in),
		.cfg        (cfg),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	// Handshake sequencer; it also decides when the pipeline moves.
	cfsl_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.res_out    (res_out)
	);

endmodule

[rtl/cfsl_checker.sv]
// ----------------------------------------------------------------------------
// cfsl_checker
// Port-level checks on the result channel of the command link master.
// ----------------------------------------------------------------------------
module cfsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        strobe_line,
	input logic [31:0] response_word,
	input logic        response_valid,
	input logic        busy_res,
	input logic        start_rejected
);

	// A finished response ends the exchange and the strobe is down.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && response_valid) |-> (!busy_res && !strobe_line))
		else $error("response delivered while exchange still active");

	// A start is only dropped while an exchange is running.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && start_rejected) |-> busy_res)
		else $error("start rejected while idle");

	// The response word is zero except on the word that completes it.
	a_resp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !response_valid) |-> (response_word == 32'd0))
		else $error("response word nonzero without response_valid");

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(response_word)
		&& $stable(response_valid) && $stable(busy_res)))
		else $error("stalled result word changed");

endmodule

bind crc_framed_serial_command_link_core cfsl_checker u_cfsl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_out.valid),
	.res_ready      (res_out.ready),
	.strobe_line    (res_out.strobe_line),
	.response_word  (res_out.response_word),
	.response_valid (res_out.response_valid),
	.busy_res       (res_out.busy_res),
	.start_rejected (res_out.start_rejected)
);
